// File: rtl/core/htfd_pkg.sv
// ----------------------------------------------------------------------------
// htfd_pkg
// Shared types, constants and helpers for the measurement frame decoder.
// ----------------------------------------------------------------------------
package htfd_pkg;

  localparam logic [7:0]  CRC_INIT    = 8'hFF;
  localparam logic [7:0]  CRC_POLY    = 8'h31;
  localparam logic [10:0] TEMP_SPAN   = 11'd1750;
  localparam logic [9:0]  HUM_SPAN    = 10'd1000;
  localparam logic [8:0]  TEMP_OFFSET = 9'd450;
  localparam logic [6:0]  OUT_SCALE   = 7'd100;

  localparam int TPROD_W = 27;  // 1750 * 65535 < 2**27
  localparam int HPROD_W = 26;  // 1000 * 65535 < 2**26

  typedef struct packed {
    logic [7:0] temp_msb;
    logic [7:0] temp_lsb;
    logic [7:0] temp_check;
    logic [7:0] hum_msb;
    logic [7:0] hum_lsb;
    logic [7:0] hum_check;
  } in_word_t;

  typedef struct packed {
    logic signed [17:0] temp_milli_c;
    logic [16:0]        hum_milli_pct;
    logic               check_fail;
  } out_word_t;

  // after first stage: CRC over the high bytes, scaled raw words
  typedef struct packed {
    logic [7:0]         crc_t;
    logic [7:0]         crc_h;
    logic [7:0]         temp_lsb;
    logic [7:0]         hum_lsb;
    logic [7:0]         temp_check;
    logic [7:0]         hum_check;
    logic [TPROD_W-1:0] tprod;
    logic [HPROD_W-1:0] hprod;
  } s1_t;

  // after second stage: full CRCs, quotients
  typedef struct packed {
    logic [7:0]  crc_t;
    logic [7:0]  crc_h;
    logic [7:0]  temp_check;
    logic [7:0]  hum_check;
    logic [10:0] qt;
    logic [9:0]  qh;
  } s2_t;

  // one byte of CRC-8, MSB first, no reflection
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                           input logic [7:0] data);
    logic [7:0] c;
    c = crc_in ^ data;
    for (int b = 0; b < 8; b++) begin
      if (c[7]) c = {c[6:0], 1'b0} ^ CRC_POLY;
      else      c = {c[6:0], 1'b0};
    end
    return c;
  endfunction

  // floor(x / 65535) for x < 65535 * 65536: (x + (x >> 16) + 1) >> 16
  function automatic logic [11:0] div_ffff(input logic [TPROD_W-1:0] x);
    logic [TPROD_W:0] s;
    s = {1'b0, x} + (TPROD_W+1)'(x >> 16) + (TPROD_W+1)'(1);
    return s[TPROD_W:16];
  endfunction

endpackage

// File: rtl/core/humidity_temp_frame_decode.sv
// ----------------------------------------------------------------------------
// humidity_temp_frame_decode
// Decodes a six-byte humidity/temperature measurement frame.
// ----------------------------------------------------------------------------
// Takes one frame word per cycle and returns one result word per frame, in
// order. Stage 1 runs the CRC-8 (poly 0x31, init 0xFF) over each high byte
// and multiplies the raw words by their span, stage 2 finishes the CRCs and
// divides by 65535 with an add-and-shift, stage 3 compares the CRCs and
// scales to milli-units into the output register. Sustained rate is one word
// per cycle; a stall on the output fills bubbles first, so input keeps
// flowing until all three stages hold a word. On a CRC mismatch check_fail
// is set and both values read zero.
module humidity_temp_frame_decode import htfd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  logic s1_valid;
  logic s1_ready;
  s1_t  s1_data;
  logic s2_valid;
  logic s2_ready;
  s2_t  s2_data;

  htfd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (s1_valid),
    .out_ready (s1_ready),
    .out_data  (s1_data)
  );

  htfd_mid u_mid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .in_data   (s1_data),
    .out_valid (s2_valid),
    .out_ready (s2_ready),
    .out_data  (s2_data)
  );

  htfd_out u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_valid),
    .in_ready  (s2_ready),
    .in_data   (s2_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule

// File: rtl/core/htfd_front.sv
// ----------------------------------------------------------------------------
// htfd_front
// Stage 1: CRC over the high bytes, raw words times their span constants.
// ----------------------------------------------------------------------------
module htfd_front import htfd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_word_t in_word,
  output logic     out_valid,
  input  logic     out_ready,
  output s1_t      out_data
);

  s1_t  data_next;
  logic valid;
  s1_t  data;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  always_comb begin
    data_next.crc_t      = crc8_byte(CRC_INIT, in_word.temp_msb);
    data_next.crc_h      = crc8_byte(CRC_INIT, in_word.hum_msb);
    data_next.temp_lsb   = in_word.temp_lsb;
    data_next.hum_lsb    = in_word.hum_lsb;
    data_next.temp_check = in_word.temp_check;
    data_next.hum_check  = in_word.hum_check;
    data_next.tprod      = TPROD_W'(TEMP_SPAN) *
                           TPROD_W'({in_word.temp_msb, in_word.temp_lsb});
    data_next.hprod      = HPROD_W'(HUM_SPAN) *
                           HPROD_W'({in_word.hum_msb, in_word.hum_lsb});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data <= data_next;
    end
  end

endmodule

// File: rtl/core/htfd_mid.sv
// ----------------------------------------------------------------------------
// htfd_mid
// Stage 2: CRC over the low bytes, quotients by 65535.
// ----------------------------------------------------------------------------
module htfd_mid import htfd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  s1_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output s2_t  out_data
);

  s2_t         data_next;
  logic [11:0] qt_full;
  logic [11:0] qh_full;
  logic        valid;
  s2_t         data;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  always_comb begin
    qt_full              = div_ffff(in_data.tprod);
    qh_full              = div_ffff(TPROD_W'(in_data.hprod));
    data_next.crc_t      = crc8_byte(in_data.crc_t, in_data.temp_lsb);
    data_next.crc_h      = crc8_byte(in_data.crc_h, in_data.hum_lsb);
    data_next.temp_check = in_data.temp_check;
    data_next.hum_check  = in_data.hum_check;
    data_next.qt         = qt_full[10:0];
    data_next.qh         = qh_full[9:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data <= data_next;
    end
  end

endmodule

// File: rtl/core/htfd_out.sv
// ----------------------------------------------------------------------------
// htfd_out
// Stage 3: CRC compare, offset and scale to milli-units, output register.
// ----------------------------------------------------------------------------
module htfd_out import htfd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  s2_t       in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  out_word_t          word_next;
  logic               bad;
  logic signed [11:0] t_off;
  logic signed [17:0] temp_val;
  logic [16:0]        hum_val;
  logic               valid;
  out_word_t          word;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_word  = word;

  always_comb begin
    bad      = (in_data.crc_t != in_data.temp_check) ||
               (in_data.crc_h != in_data.hum_check);
    t_off    = $signed({1'b0, in_data.qt}) - $signed({3'b000, TEMP_OFFSET});
    temp_val = 18'(t_off) * $signed({11'd0, OUT_SCALE});
    hum_val  = 17'(in_data.qh) * 17'(OUT_SCALE);
    word_next.temp_milli_c  = bad ? '0 : temp_val;
    word_next.hum_milli_pct = bad ? '0 : hum_val;
    word_next.check_fail    = bad;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word <= word_next;
    end
  end

endmodule

// File: rtl/core/htfd_checker.sv
// ----------------------------------------------------------------------------
// htfd_checker
// Port-level checks on the frame decoder, bound to the top level.
// ----------------------------------------------------------------------------
module htfd_checker import htfd_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_word
);

  // held result word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  // nothing held at the output means the whole pipe can move
  a_in_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.check_fail |->
      out_word.temp_milli_c == '0 && out_word.hum_milli_pct == '0)
    else $error("nonzero values on CRC failure");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_word.check_fail |->
      out_word.hum_milli_pct <= 17'd100000 &&
      out_word.temp_milli_c >= -18'sd45000 &&
      out_word.temp_milli_c <= 18'sd130000)
    else $error("value out of range");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind humidity_temp_frame_decode htfd_checker u_htfd_checker (.*);

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Frame decoder check: CRC-8 validation and scaling of temperature/humidity.
// ----------------------------------------------------------------------------
// Drives measurement frames through valid/ready with random gaps on both
// sides and compares every result word against a local decode of the frame.
// A directed set covers zero and full scale, the values around the
// truncation steps, the zero-degree crossing and CRC errors on either or
// both words. The random part is mostly frames with correct CRCs and some
// with corrupted check bytes.
// ----------------------------------------------------------------------------
module testbench;
  import htfd_pkg::*;

  localparam logic [7:0] CRC_SEED  = 8'hFF;
  localparam logic [7:0] CRC_GEN   = 8'h31;
  localparam int         RAW_MAX   = 65535;
  localparam int         T_SPAN    = 1750;
  localparam int         T_OFFSET  = 450;
  localparam int         H_SPAN    = 1000;
  localparam int         SCALE     = 100;
  localparam int         N_RANDOM  = 900;
  localparam int         STALL_MAX = 500;

  class reading_tracker;
    out_word_t expected_readings[$];
    int        fails = 0;

    function logic [7:0] word_crc(logic [7:0] hi, logic [7:0] lo);
      logic [7:0]  c;
      logic [15:0] bits;
      c = CRC_SEED;
      bits = {hi, lo};
      for (int i = 15; i >= 0; i--) begin
        if (c[7] ^ bits[i]) c = {c[6:0], 1'b0} ^ CRC_GEN;
        else                c = {c[6:0], 1'b0};
      end
      return c;
    endfunction

    function out_word_t decode_frame(in_word_t f);
      out_word_t r;
      int        tq;
      int        hq;
      r = '0;
      if (word_crc(f.temp_msb, f.temp_lsb) != f.temp_check ||
          word_crc(f.hum_msb, f.hum_lsb) != f.hum_check) begin
        r.check_fail = 1'b1;
        return r;
      end
      tq = (T_SPAN * int'({f.temp_msb, f.temp_lsb})) / RAW_MAX;
      hq = (H_SPAN * int'({f.hum_msb, f.hum_lsb})) / RAW_MAX;
      r.temp_milli_c  = 18'((tq - T_OFFSET) * SCALE);
      r.hum_milli_pct = 17'(hq * SCALE);
      return r;
    endfunction

    function void note_frame(in_word_t f);
      expected_readings.push_back(decode_frame(f));
    endfunction

    function void check_reading(out_word_t got);
      out_word_t want;
      if (expected_readings.size() == 0) begin
        $error("unexpected result word: temp %0d hum %0d fail %0b",
               got.temp_milli_c, got.hum_milli_pct, got.check_fail);
        fails++;
        return;
      end
      want = expected_readings.pop_front();
      if (got.temp_milli_c !== want.temp_milli_c) begin
        $error("temp_milli_c: expected %0d, got %0d", want.temp_milli_c, got.temp_milli_c);
        fails++;
      end
      if (got.hum_milli_pct !== want.hum_milli_pct) begin
        $error("hum_milli_pct: expected %0d, got %0d", want.hum_milli_pct, got.hum_milli_pct);
        fails++;
      end
      if (got.check_fail !== want.check_fail) begin
        $error("check_fail: expected %0b, got %0b", want.check_fail, got.check_fail);
        fails++;
      end
    endfunction

    function int pending();
      return expected_readings.size();
    endfunction
  endclass

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_word;

  reading_tracker tracker = new();
  int             idle_cycles = 0;
  bit             calm_send = 0;

  humidity_temp_frame_decode u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word (out_word)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // xor masks of zero give a frame with correct CRCs
  function in_word_t make_frame(logic [15:0] t, logic [15:0] h,
                                logic [7:0] t_err, logic [7:0] h_err);
    in_word_t f;
    f.temp_msb   = t[15:8];
    f.temp_lsb   = t[7:0];
    f.temp_check = tracker.word_crc(t[15:8], t[7:0]) ^ t_err;
    f.hum_msb    = h[15:8];
    f.hum_lsb    = h[7:0];
    f.hum_check  = tracker.word_crc(h[15:8], h[7:0]) ^ h_err;
    return f;
  endfunction

  task send_frame(in_word_t f);
    int gap;
    gap = calm_send ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= f;
    do @(posedge clk); while (!in_ready);
    tracker.note_frame(f);
  endtask

  task drain_readings();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
  endtask

  // result monitor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) tracker.check_reading(out_word);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_MAX) begin
        $display("tb: failure");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // receiver: random stall before each result word, with calm stretches
  initial begin
    int stall;
    int n;
    bit calm;
    n = 0;
    calm = 0;
    out_ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (n % 50 == 0) calm = ($urandom_range(0, 2) == 0);
      stall = calm ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      n++;
    end
  end

  initial begin
    logic [15:0] t;
    logic [15:0] h;
    logic [7:0]  t_err;
    logic [7:0]  h_err;
    int          kind;
    rst      <= 1'b1;
    in_valid <= 1'b0;
    in_word  <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: scale ends, truncation steps, zero crossing, CRC errors
    send_frame(make_frame(16'h0000, 16'h0000, 8'h00, 8'h00));
    send_frame(make_frame(16'hFFFF, 16'hFFFF, 8'h00, 8'h00));
    send_frame(make_frame(16'hFFFE, 16'hFFFE, 8'h00, 8'h00));
    send_frame(make_frame(16'd37,   16'd65,   8'h00, 8'h00));
    send_frame(make_frame(16'd38,   16'd66,   8'h00, 8'h00));
    send_frame(make_frame(16'd16852, 16'd32767, 8'h00, 8'h00));
    send_frame(make_frame(16'd16853, 16'd32768, 8'h00, 8'h00));
    send_frame(make_frame(16'h8000, 16'h7FFF, 8'h00, 8'h00));
    send_frame(make_frame(16'h5555, 16'hAAAA, 8'h00, 8'h00));
    send_frame(make_frame(16'hAAAA, 16'h5555, 8'h00, 8'h00));
    send_frame(make_frame(16'h1234, 16'h5678, 8'h01, 8'h00));
    send_frame(make_frame(16'h1234, 16'h5678, 8'h00, 8'h80));
    send_frame(make_frame(16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF));
    send_frame(make_frame(16'h0000, 16'h0000, 8'h00, 8'h01));
    send_frame(make_frame(16'hFFFF, 16'h0000, 8'h80, 8'h00));
    calm_send = 1;
    send_frame(make_frame(16'h6666, 16'h9999, 8'h00, 8'h00));
    send_frame(make_frame(16'h9999, 16'h6666, 8'h00, 8'h00));
    send_frame(make_frame(16'hC000, 16'h4000, 8'h00, 8'h00));
    calm_send = 0;

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 64 == 0) calm_send = ($urandom_range(0, 2) == 0);
      if (i == 300 || i == 600) drain_readings();
      t = 16'($urandom);
      h = 16'($urandom);
      t_err = '0;
      h_err = '0;
      kind = $urandom_range(0, 9);
      if (kind == 8) begin
        if ($urandom_range(0, 1)) t_err = 8'($urandom_range(1, 255));
        else                      h_err = 8'($urandom_range(1, 255));
      end else if (kind == 9) begin
        t_err = 8'($urandom_range(0, 255));
        h_err = 8'($urandom_range(1, 255));
      end
      send_frame(make_frame(t, h, t_err, h_err));
    end

    drain_readings();
    repeat (10) @(posedge clk);
    if (tracker.pending() != 0) begin
      $error("%0d result words never arrived", tracker.pending());
      tracker.fails++;
    end
    if (tracker.fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
